// File: rtl/csgmd_pkg.sv
// Shared constants, types and helper functions of the corner-matching distance block.
`timescale 1ns / 1ps

package csgmd_pkg;

	// Coordinate format and corner counts
	localparam int COORD_BITS = 16;
	localparam int NCORNERS   = 4;
	localparam int NPAIRS     = NCORNERS * NCORNERS;
	localparam int NREGS      = 2 * NCORNERS;

	// Datapath widths: |diff| fits the coordinate width, squares take twice it, distances one bit more, capped at 64
	localparam int ABS_W  = COORD_BITS;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DIST_W = (2 * COORD_BITS + 1 > 64) ? 64 : 2 * COORD_BITS + 1;
	localparam int OUT_W  = 35;

	// Stream and configuration port widths
	localparam int IN_W         = NREGS * COORD_BITS;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W    = 4;

	typedef logic [NPAIRS-1:0][ABS_W-1:0]  abs_arr_t;
	typedef logic [NPAIRS-1:0][SQ_W-1:0]   sq_arr_t;
	typedef logic [NPAIRS-1:0][DIST_W-1:0] dist_arr_t;
	// ord[i][j] set when pair i is taken before pair j
	typedef logic [NPAIRS-1:0][NPAIRS-1:0] order_t;

	// Progress of the greedy pick
	typedef struct packed {
		logic [NCORNERS-1:0] ref_used;
		logic [NCORNERS-1:0] cand_used;
		logic [OUT_W-1:0]    sum;
	} pick_t;

	// Total order over pairs: smaller distance first, ties to lower pair index
	function automatic order_t pair_order(input dist_arr_t d);
		order_t o;
		o = '0;
		for (int i = 0; i < NPAIRS; i++) begin
			o[i][i] = 1'b1;
			for (int j = i + 1; j < NPAIRS; j++) begin
				o[i][j] = (d[i] <= d[j]);
				o[j][i] = !(d[i] <= d[j]);
			end
		end
		return o;
	endfunction

	// One greedy step: take the first eligible pair in the order, mark its corners, add its distance to the sum
	function automatic pick_t pick_next(input pick_t cur, input dist_arr_t d,
			input order_t o);
		logic [NPAIRS-1:0] elig;
		logic [NPAIRS-1:0] win;
		logic [DIST_W-1:0] sel;
		pick_t nxt;
		elig = '0;
		win  = '0;
		sel  = '0;
		nxt  = cur;
		for (int r = 0; r < NCORNERS; r++) begin
			for (int c = 0; c < NCORNERS; c++) begin
				elig[r*NCORNERS+c] = !cur.ref_used[r] && !cur.cand_used[c];
			end
		end
		for (int i = 0; i < NPAIRS; i++) begin
			win[i] = elig[i];
			for (int j = 0; j < NPAIRS; j++) begin
				if (j != i && elig[j] && !o[i][j]) begin
					win[i] = 1'b0;
				end
			end
		end
		for (int r = 0; r < NCORNERS; r++) begin
			for (int c = 0; c < NCORNERS; c++) begin
				if (win[r*NCORNERS+c]) begin
					sel = sel | d[r*NCORNERS+c];
					nxt.ref_used[r]  = 1'b1;
					nxt.cand_used[c] = 1'b1;
				end
			end
		end
		nxt.sum = cur.sum + OUT_W'(sel);
		return nxt;
	endfunction

endpackage

// File: rtl/corner_set_greedy_match_distance.sv
// Top level: 16 corner distances, pair ordering and four greedy picks in an 8-stage pipeline.
`timescale 1ns / 1ps
// Pipeline: 8 register stages, s1 to s8; a candidate taken on the input transfer moves
// through them in order, and its result shows on m_tvalid once it reaches s8.
// Throughput: one candidate per cycle unless m_tready holds the pipeline; every stage holds one item, and each
// stage advances when it is empty or the stage after it moves.
// Reset: arst_n clears all stage valid bits and sets the reference corners to zero.
// cfg_ready is always high; indexes beyond the eight corner registers are dropped.

module corner_set_greedy_match_distance (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tdata: cand_c0_x, cand_c0_y, cand_c1_x, cand_c1_y,
	//        cand_c2_x, cand_c2_y, cand_c3_x, cand_c3_y
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [csgmd_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tdata: match_distance, zero pad
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [csgmd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csgmd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [csgmd_pkg::COORD_BITS-1:0]     cfg_data
);

	localparam int CB = csgmd_pkg::COORD_BITS;
	localparam int NC = csgmd_pkg::NCORNERS;

	// Reference corners
	logic [csgmd_pkg::NREGS-1:0][CB-1:0] ref_q;

	// Stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic go_s1, go_s2, go_s3, go_s4, go_s5, go_s6, go_s7, go_s8;

	// Stage payloads
	csgmd_pkg::abs_arr_t  adx_s1, ady_s1;
	csgmd_pkg::sq_arr_t   sqx_s2, sqy_s2;
	csgmd_pkg::dist_arr_t dist_s3, dist_s4, dist_s5, dist_s6, dist_s7;
	csgmd_pkg::order_t    ord_s4, ord_s5, ord_s6, ord_s7;
	csgmd_pkg::pick_t     pk_s5, pk_s6, pk_s7, pk_s8;

	// Combinational stage inputs
	csgmd_pkg::abs_arr_t  adx_d, ady_d;
	csgmd_pkg::dist_arr_t dist_d;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (cfg_valid && cfg_ready &&
				cfg_index < csgmd_pkg::CFG_IDX_W'(csgmd_pkg::NREGS)) begin
			ref_q[cfg_index[$clog2(csgmd_pkg::NREGS)-1:0]] <= cfg_data;
		end
	end

	// Advance chain: a stage moves when it is empty or its successor moves
	assign go_s8 = !v_s8 || m_tready;
	assign go_s7 = !v_s7 || go_s8;
	assign go_s6 = !v_s6 || go_s7;
	assign go_s5 = !v_s5 || go_s6;
	assign go_s4 = !v_s4 || go_s5;
	assign go_s3 = !v_s3 || go_s4;
	assign go_s2 = !v_s2 || go_s3;
	assign go_s1 = !v_s1 || go_s2;

	assign s_tready = go_s1;
	assign m_tvalid = v_s8;
	assign m_tdata  = {{(csgmd_pkg::OUT_TDATA_W - csgmd_pkg::OUT_W){1'b0}}, pk_s8.sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (go_s1) v_s1 <= s_tvalid;
			if (go_s2) v_s2 <= v_s1;
			if (go_s3) v_s3 <= v_s2;
			if (go_s4) v_s4 <= v_s3;
			if (go_s5) v_s5 <= v_s4;
			if (go_s6) v_s6 <= v_s5;
			if (go_s7) v_s7 <= v_s6;
			if (go_s8) v_s8 <= v_s7;
		end
	end

	// Stage 1 logic: absolute coordinate differences for every pair
	always_comb begin
		logic signed [CB:0] dx;
		logic signed [CB:0] dy;
		logic [CB-1:0]      cx, cy, rx, ry;
		adx_d = '0;
		ady_d = '0;
		for (int r = 0; r < NC; r++) begin
			for (int c = 0; c < NC; c++) begin
				rx = ref_q[2*r];
				ry = ref_q[2*r+1];
				cx = s_tdata[(2*c)*CB +: CB];
				cy = s_tdata[(2*c+1)*CB +: CB];
				dx = $signed({rx[CB-1], rx}) - $signed({cx[CB-1], cx});
				dy = $signed({ry[CB-1], ry}) - $signed({cy[CB-1], cy});
				adx_d[r*NC+c] = dx[CB] ? CB'(-dx) : dx[CB-1:0];
				ady_d[r*NC+c] = dy[CB] ? CB'(-dy) : dy[CB-1:0];
			end
		end
	end

	// Stage 3 logic: squared distance of every pair
	always_comb begin
		for (int i = 0; i < csgmd_pkg::NPAIRS; i++) begin
			dist_d[i] = csgmd_pkg::DIST_W'(sqx_s2[i]) + csgmd_pkg::DIST_W'(sqy_s2[i]);
		end
	end

	// Stage payload registers
	always_ff @(posedge clk) begin
		if (go_s1) begin
			adx_s1 <= adx_d;
			ady_s1 <= ady_d;
		end
		// squares
		if (go_s2) begin
			for (int i = 0; i < csgmd_pkg::NPAIRS; i++) begin
				sqx_s2[i] <= csgmd_pkg::SQ_W'(adx_s1[i]) * csgmd_pkg::SQ_W'(adx_s1[i]);
				sqy_s2[i] <= csgmd_pkg::SQ_W'(ady_s1[i]) * csgmd_pkg::SQ_W'(ady_s1[i]);
			end
		end
		if (go_s3) begin
			dist_s3 <= dist_d;
		end
		// pairwise order matrix
		if (go_s4) begin
			dist_s4 <= dist_s3;
			ord_s4  <= csgmd_pkg::pair_order(dist_s3);
		end
		// greedy picks, one per stage
		if (go_s5) begin
			dist_s5 <= dist_s4;
			ord_s5  <= ord_s4;
			pk_s5   <= csgmd_pkg::pick_next('0, dist_s4, ord_s4);
		end
		if (go_s6) begin
			dist_s6 <= dist_s5;
			ord_s6  <= ord_s5;
			pk_s6   <= csgmd_pkg::pick_next(pk_s5, dist_s5, ord_s5);
		end
		if (go_s7) begin
			dist_s7 <= dist_s6;
			ord_s7  <= ord_s6;
			pk_s7   <= csgmd_pkg::pick_next(pk_s6, dist_s6, ord_s6);
		end
		if (go_s8) begin
			pk_s8 <= csgmd_pkg::pick_next(pk_s7, dist_s7, ord_s7);
		end
	end

endmodule
